### sv/dlwa_pkg.sv
// ----------------------------------------------------------------------------
// dlwa_pkg
// Types, codes and constants shared by the dense layer modules.
// ----------------------------------------------------------------------------
package dlwa_pkg;

	typedef struct packed {
		logic [1:0]         func;
		logic [13:0]        index;
		logic signed [15:0] value;
		logic               is_last;
	} in_word_t;

	typedef struct packed {
		logic signed [16:0] out_value;
		logic [5:0]         out_index;
		logic               last;
	} out_word_t;

	localparam logic [1:0] FUNC_WEIGHT = 2'd0;
	localparam logic [1:0] FUNC_BIAS   = 2'd1;
	localparam logic [1:0] FUNC_INPUT  = 2'd2;

	localparam logic [1:0] CFG_IN_COUNT   = 2'd0;
	localparam logic [1:0] CFG_OUT_COUNT  = 2'd1;
	localparam logic [1:0] CFG_ACTIVATION = 2'd2;

	localparam logic [1:0] ACT_RELU    = 2'd1;
	localparam logic [1:0] ACT_SOFTMAX = 2'd2;

	localparam logic [16:0] EXP2_TABLE [16] = '{
		17'd65536, 17'd68438, 17'd71468, 17'd74632, 17'd77936, 17'd81386,
		17'd84990, 17'd88752, 17'd92682, 17'd96785, 17'd101070, 17'd105545,
		17'd110218, 17'd115098, 17'd120194, 17'd125515
	};

	localparam logic signed [42:0] LOG2E_Q8 = 43'sd369;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_MAC,
		ST_DRAIN,
		ST_NEURON,
		ST_SUM_RD,
		ST_SUM_MUL,
		ST_SUM_EXP,
		ST_DIV_RD,
		ST_DIV_MUL,
		ST_DIV_EXP,
		ST_DIV,
		ST_LIN_RD,
		ST_LIN_CALC,
		ST_EMIT
	} ctrl_state_t;

	typedef struct packed {
		logic in_ready;
		logic mac_issue;
		logic nb_we;
		logic o_step;
		logic exp_mul;
		logic sum_add;
		logic div_start;
		logic lin_calc;
		logic out_load;
	} ctrl_cmd_t;

	typedef struct packed {
		logic start;
		logic i_last;
		logic o_last;
		logic softmax;
		logic div_busy;
		logic out_free;
	} ctrl_sts_t;

endpackage

### sv/dlwa_ram.sv
// ----------------------------------------------------------------------------
// dlwa_ram
// Generic simple dual-port RAM with one write port and a registered read.
// ----------------------------------------------------------------------------
module dlwa_ram #(
	parameter int W = 16,
	parameter int D = 64,
	parameter int AW = (D > 1) ? $clog2(D) : 1
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [W-1:0]  wdata,
	input  logic [AW-1:0] raddr,
	output logic [W-1:0]  rdata
);

	logic [W-1:0] mem_q [D];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

### sv/dlwa_ctrl.sv
// ----------------------------------------------------------------------------
// dlwa_ctrl
// Sequencer for the layer run: accumulate, activation passes and output.
// ----------------------------------------------------------------------------
module dlwa_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  dlwa_pkg::ctrl_sts_t   sts,
	output dlwa_pkg::ctrl_cmd_t   cmd
);

	dlwa_pkg::ctrl_state_t state_q, state_d;
	logic drain_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= dlwa_pkg::ST_IDLE;
			drain_q <= 1'b0;
		end else begin
			state_q <= state_d;
			drain_q <= (state_q == dlwa_pkg::ST_DRAIN) ? ~drain_q : 1'b0;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			dlwa_pkg::ST_IDLE: begin
				if (sts.start) state_d = dlwa_pkg::ST_MAC;
			end
			dlwa_pkg::ST_MAC: begin
				if (sts.i_last) state_d = dlwa_pkg::ST_DRAIN;
			end
			dlwa_pkg::ST_DRAIN: begin
				if (drain_q) state_d = dlwa_pkg::ST_NEURON;
			end
			dlwa_pkg::ST_NEURON: begin
				if (!sts.o_last) state_d = dlwa_pkg::ST_MAC;
				else if (sts.softmax) state_d = dlwa_pkg::ST_SUM_RD;
				else state_d = dlwa_pkg::ST_LIN_RD;
			end
			dlwa_pkg::ST_SUM_RD:  state_d = dlwa_pkg::ST_SUM_MUL;
			dlwa_pkg::ST_SUM_MUL: state_d = dlwa_pkg::ST_SUM_EXP;
			dlwa_pkg::ST_SUM_EXP: begin
				state_d = sts.o_last ? dlwa_pkg::ST_DIV_RD : dlwa_pkg::ST_SUM_RD;
			end
			dlwa_pkg::ST_DIV_RD:  state_d = dlwa_pkg::ST_DIV_MUL;
			dlwa_pkg::ST_DIV_MUL: state_d = dlwa_pkg::ST_DIV_EXP;
			dlwa_pkg::ST_DIV_EXP: state_d = dlwa_pkg::ST_DIV;
			dlwa_pkg::ST_DIV: begin
				if (!sts.div_busy) state_d = dlwa_pkg::ST_EMIT;
			end
			dlwa_pkg::ST_LIN_RD:   state_d = dlwa_pkg::ST_LIN_CALC;
			dlwa_pkg::ST_LIN_CALC: state_d = dlwa_pkg::ST_EMIT;
			dlwa_pkg::ST_EMIT: begin
				if (sts.out_free) begin
					if (sts.o_last) state_d = dlwa_pkg::ST_IDLE;
					else if (sts.softmax) state_d = dlwa_pkg::ST_DIV_RD;
					else state_d = dlwa_pkg::ST_LIN_RD;
				end
			end
			default: state_d = dlwa_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		case (state_q)
			dlwa_pkg::ST_IDLE:     cmd.in_ready = 1'b1;
			dlwa_pkg::ST_MAC:      cmd.mac_issue = 1'b1;
			dlwa_pkg::ST_NEURON: begin
				cmd.nb_we  = 1'b1;
				cmd.o_step = 1'b1;
			end
			dlwa_pkg::ST_SUM_MUL:  cmd.exp_mul = 1'b1;
			dlwa_pkg::ST_SUM_EXP: begin
				cmd.sum_add = 1'b1;
				cmd.o_step  = 1'b1;
			end
			dlwa_pkg::ST_DIV_MUL:  cmd.exp_mul = 1'b1;
			dlwa_pkg::ST_DIV_EXP:  cmd.div_start = 1'b1;
			dlwa_pkg::ST_LIN_CALC: cmd.lin_calc = 1'b1;
			dlwa_pkg::ST_EMIT: begin
				cmd.out_load = sts.out_free;
				cmd.o_step   = sts.out_free;
			end
			default: cmd = '0;
		endcase
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		sts.start |=> state_q == dlwa_pkg::ST_MAC)
		else $error("run start did not enter accumulation");

	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.div_start |-> !sts.div_busy)
		else $error("divider restarted while busy");

	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == dlwa_pkg::ST_DRAIN && drain_q) |=> state_q == dlwa_pkg::ST_NEURON)
		else $error("drain did not end in neuron write");

endmodule

### sv/dlwa_dp.sv
// ----------------------------------------------------------------------------
// dlwa_dp
// Datapath: stores, shared MAC, exp unit, serial divider and output register.
// ----------------------------------------------------------------------------
module dlwa_dp #(
	parameter int MAX_IN = 256,
	parameter int MAX_OUT = 64
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	input  dlwa_pkg::in_word_t    in_data,
	input  logic                  out_stall,
	output logic                  out_valid,
	output dlwa_pkg::out_word_t   out_data,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [1:0]            cfg_index,
	input  logic [8:0]            cfg_data,
	input  dlwa_pkg::ctrl_cmd_t   cmd,
	output dlwa_pkg::ctrl_sts_t   sts
);

	localparam int OL = (MAX_OUT < 64) ? MAX_OUT : 64;
	localparam int WD = MAX_IN * MAX_OUT;
	localparam int IW = (MAX_IN > 1) ? $clog2(MAX_IN) : 1;
	localparam int BAW = (MAX_OUT > 1) ? $clog2(MAX_OUT) : 1;
	localparam int OAW = (OL > 1) ? $clog2(OL) : 1;
	localparam int WAW = (WD > 1) ? $clog2(WD) : 1;

	logic [8:0] in_count_q;
	logic [6:0] out_count_q;
	logic [1:0] mode_q;

	logic accept, start;
	logic [31:0] idx32;

	logic [IW-1:0] i_q, nim1_q;
	logic [5:0] o_q, nom1_q;
	logic i_last, o_last;

	logic [15:0] x_rd, w_rd, b_rd;
	logic [31:0] nb_rd;
	logic [31:0] w_raddr32, o32, ni_m1_32, no_m1_32;

	logic v1_q, v2_q;
	logic signed [31:0] prod_s2;
	logic signed [47:0] acc_q, acc_sh, nsum;
	logic signed [31:0] nv, max_q;

	logic signed [32:0] d;
	logic signed [42:0] eprod_q, y, k, s;
	logic [16:0] e;
	logic [22:0] sum_q;

	logic div_busy_q;
	logic [5:0] div_cnt_q;
	logic [23:0] rem_q, remx;
	logic [33:0] nq_q;
	logic qbit;
	logic [15:0] q_sat;

	logic signed [31:0] lin_v;
	logic signed [16:0] lin_q;

	assign accept = in_valid && cmd.in_ready;
	assign start = accept && in_data.func == dlwa_pkg::FUNC_INPUT && in_data.is_last;
	assign idx32 = 32'(in_data.index);
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_count_q <= 9'd256;
			out_count_q <= 7'd64;
			mode_q <= 2'd0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				dlwa_pkg::CFG_IN_COUNT:   in_count_q <= cfg_data;
				dlwa_pkg::CFG_OUT_COUNT:  out_count_q <= cfg_data[6:0];
				dlwa_pkg::CFG_ACTIVATION: mode_q <= cfg_data[1:0];
				default: ;
			endcase
		end
	end

	assign ni_m1_32 = (in_count_q == 9'd0) ? 32'd0 :
		(32'(in_count_q) > MAX_IN) ? 32'(MAX_IN - 1) : 32'(in_count_q) - 32'd1;
	assign no_m1_32 = (out_count_q == 7'd0) ? 32'd0 :
		(32'(out_count_q) > OL) ? 32'(OL - 1) : 32'(out_count_q) - 32'd1;

	assign i_last = i_q == nim1_q;
	assign o_last = o_q == nom1_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			i_q <= '0;
			o_q <= '0;
			nim1_q <= '0;
			nom1_q <= '0;
		end else begin
			if (start) begin
				i_q <= '0;
				o_q <= '0;
				nim1_q <= ni_m1_32[IW-1:0];
				nom1_q <= no_m1_32[5:0];
			end else begin
				if (cmd.mac_issue) i_q <= i_last ? '0 : i_q + 1'b1;
				if (cmd.o_step) o_q <= o_last ? 6'd0 : o_q + 6'd1;
			end
		end
	end

	assign o32 = 32'(o_q);
	assign w_raddr32 = 32'(i_q) * MAX_OUT + o32;

	dlwa_ram #(.W(16), .D(WD)) u_weight (
		.clk(clk),
		.we(accept && in_data.func == dlwa_pkg::FUNC_WEIGHT && idx32 < WD),
		.waddr(idx32[WAW-1:0]),
		.wdata(in_data.value),
		.raddr(w_raddr32[WAW-1:0]),
		.rdata(w_rd)
	);

	dlwa_ram #(.W(16), .D(MAX_OUT)) u_bias (
		.clk(clk),
		.we(accept && in_data.func == dlwa_pkg::FUNC_BIAS && idx32 < MAX_OUT),
		.waddr(idx32[BAW-1:0]),
		.wdata(in_data.value),
		.raddr(o32[BAW-1:0]),
		.rdata(b_rd)
	);

	dlwa_ram #(.W(16), .D(MAX_IN)) u_input (
		.clk(clk),
		.we(accept && in_data.func == dlwa_pkg::FUNC_INPUT && idx32 < MAX_IN),
		.waddr(idx32[IW-1:0]),
		.wdata(in_data.value),
		.raddr(i_q),
		.rdata(x_rd)
	);

	dlwa_ram #(.W(32), .D(OL)) u_neuron (
		.clk(clk),
		.we(cmd.nb_we),
		.waddr(o32[OAW-1:0]),
		.wdata(nv),
		.raddr(o32[OAW-1:0]),
		.rdata(nb_rd)
	);

	// Multiply-accumulate pipeline: read, product, accumulate.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1_q <= 1'b0;
			v2_q <= 1'b0;
		end else begin
			v1_q <= cmd.mac_issue;
			v2_q <= v1_q;
		end
	end

	always_ff @(posedge clk) begin
		prod_s2 <= $signed(x_rd) * $signed(w_rd);
		if (start || cmd.nb_we) begin
			acc_q <= '0;
		end else if (v2_q) begin
			acc_q <= acc_q + 48'(prod_s2);
		end
	end

	assign acc_sh = acc_q >>> 8;
	assign nsum = acc_sh + 48'($signed(b_rd));
	assign nv = (nsum > 48'sd2147483647) ? 32'sh7fffffff :
		(nsum < -48'sd2147483648) ? 32'sh80000000 : nsum[31:0];

	always_ff @(posedge clk) begin
		if (cmd.nb_we && (o_q == 6'd0 || nv > max_q)) begin
			max_q <= nv;
		end
	end

	// Exponential approximation, shared by the sum and divide passes.
	assign d = 33'($signed(nb_rd)) - 33'(max_q);

	always_ff @(posedge clk) begin
		if (cmd.exp_mul) eprod_q <= 43'(d) * dlwa_pkg::LOG2E_Q8;
		if (start) sum_q <= '0;
		else if (cmd.sum_add) sum_q <= sum_q + 23'(e);
	end

	assign y = eprod_q >>> 8;
	assign k = y >>> 8;
	assign s = -k;
	assign e = (s > 43'sd31) ? 17'd0 : (dlwa_pkg::EXP2_TABLE[y[7:4]] >> s[4:0]);

	// Restoring divider, one quotient bit per cycle.
	assign remx = {rem_q[22:0], nq_q[33]};
	assign qbit = remx >= {1'b0, sum_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			div_busy_q <= 1'b0;
			div_cnt_q <= '0;
		end else if (cmd.div_start) begin
			div_busy_q <= 1'b1;
			div_cnt_q <= 6'd34;
		end else if (div_busy_q) begin
			div_cnt_q <= div_cnt_q - 6'd1;
			div_busy_q <= div_cnt_q != 6'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.div_start) begin
			rem_q <= '0;
			nq_q <= (34'(e) << 16) + 34'(sum_q >> 1);
		end else if (div_busy_q) begin
			rem_q <= qbit ? remx - {1'b0, sum_q} : remx;
			nq_q <= {nq_q[32:0], qbit};
		end
	end

	assign q_sat = (nq_q > 34'd65535) ? 16'hffff : nq_q[15:0];

	// Linear and ReLU output path.
	assign lin_v = (mode_q == dlwa_pkg::ACT_RELU && $signed(nb_rd) < 0) ? 32'sd0 :
		$signed(nb_rd);

	always_ff @(posedge clk) begin
		if (cmd.lin_calc) begin
			lin_q <= (lin_v > 32'sd65535) ? 17'sd65535 :
				(lin_v < -32'sd65536) ? -17'sd65536 : lin_v[16:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid <= 1'b1;
		end else if (!out_stall) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			out_data.out_value <= (mode_q == dlwa_pkg::ACT_SOFTMAX) ?
				$signed({1'b0, q_sat}) : lin_q;
			out_data.out_index <= o_q;
			out_data.last <= o_last;
		end
	end

	assign sts.start = start;
	assign sts.i_last = i_last;
	assign sts.o_last = o_last;
	assign sts.softmax = mode_q == dlwa_pkg::ACT_SOFTMAX;
	assign sts.div_busy = div_busy_q;
	assign sts.out_free = !out_valid || !out_stall;

	assert property (@(posedge clk) disable iff (!arst_n)
		div_busy_q |-> sum_q >= 23'd65536)
		else $error("softmax sum below the maximum term");

	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> (!out_valid || !out_stall))
		else $error("output word overwritten while stalled");

endmodule

### sv/dense_layer_with_activation.sv
// ----------------------------------------------------------------------------
// dense_layer_with_activation
// Fully connected layer with none, ReLU or softmax activation.
// ----------------------------------------------------------------------------
// Input words load weights, biases or input elements, one word per cycle
// while the block is idle. An input element with is_last set starts a run;
// in_stall then stays high until the last result has entered the output
// register. The neurons accumulate one after another on the single shared
// MAC, and ReLU and linear results then follow one neuron at a time.
// Softmax adds a sum pass over all neurons and then a divide pass for each
// neuron on the one-bit-per-cycle divider. Results leave in neuron order
// through a single output register; while out_stall is high the word holds
// and the sequencer waits. Reset clears control state and sets in_count to
// 256, out_count to 64 and activation_mode to none; the stores hold no reset
// value and need no clearing pass. Configuration writes are taken on any
// cycle and must be made while no run is in progress.
// ----------------------------------------------------------------------------
module dense_layer_with_activation #(
	parameter int MAX_IN = 256,
	parameter int MAX_OUT = 64
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  dlwa_pkg::in_word_t  in_data,
	output logic                out_valid,
	input  logic                out_stall,
	output dlwa_pkg::out_word_t out_data,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [1:0]          cfg_index,
	input  logic [8:0]          cfg_data
);

	dlwa_pkg::ctrl_cmd_t cmd;
	dlwa_pkg::ctrl_sts_t sts;

	assign in_stall = ~cmd.in_ready;

	dlwa_ctrl u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.sts(sts),
		.cmd(cmd)
	);

	dlwa_dp #(.MAX_IN(MAX_IN), .MAX_OUT(MAX_OUT)) u_dp (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_data(in_data),
		.out_stall(out_stall),
		.out_valid(out_valid),
		.out_data(out_data),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.cmd(cmd),
		.sts(sts)
	);

endmodule

### tb/dense_layer_with_activation_tb.sv
// ----------------------------------------------------------------------------
// dense_layer_with_activation_tb
// Self-checking testbench for the dense layer with activation.
// ----------------------------------------------------------------------------
// The store entries that later runs read are filled first, so no run reads
// an entry that was never written. A short table of directed words follows,
// then random phases, each under its own register setting. The table or a
// behavioral model in the testbench gives every expected result word; the
// output is checked word by word. Input idles and output stalls at random.
// ----------------------------------------------------------------------------
module dense_layer_with_activation_tb;

	localparam int N_IN = 256;
	localparam int N_OUT = 64;
	localparam int FILL_IN = 6;
	localparam int FILL_OUT = 6;
	localparam int STALL_LIMIT = 4000;
	localparam logic [1:0] ACT_NONE = 2'd0;
	localparam logic [1:0] ACT_UNKNOWN = 2'd3;
	localparam logic [1:0] FUNC_UNKNOWN = 2'd3;

	typedef struct {
		logic [1:0]         mode;
		dlwa_pkg::in_word_t word;
		bit                 typed;
		logic signed [16:0] result;
	} table_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	dlwa_pkg::in_word_t in_data = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	dlwa_pkg::out_word_t out_data;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [1:0] cfg_index = '0;
	logic [8:0] cfg_data = '0;

	logic signed [15:0] weights [N_IN * N_OUT];
	logic signed [15:0] biases [N_OUT];
	logic signed [15:0] inputs [N_IN];
	logic [8:0] in_count_reg = 9'd256;
	logic [6:0] out_count_reg = 7'd64;
	logic [1:0] act_mode_reg = ACT_NONE;

	dlwa_pkg::out_word_t pending_words [$];
	int mismatches = 0;
	int idle_cycles = 0;
	bit calm = 1'b0;
	int sent = 0;

	dense_layer_with_activation uut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
		.out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always #6 clk = ~clk;

	function automatic longint unsigned exp_of(longint d);
		longint y, k, f;
		y = (d * 369) >>> 8;
		k = y >>> 8;
		f = y - k * 256;
		if (-k > 31)
			return 0;
		return longint'(dlwa_pkg::EXP2_TABLE[f >> 4]) >> (-k);
	endfunction

	task automatic compute_layer(input bit keep);
		int ni, no;
		longint acc, mx;
		longint v [N_OUT];
		longint unsigned e [N_OUT];
		longint unsigned sum, q;
		dlwa_pkg::out_word_t w;
		ni = in_count_reg == 0 ? 1 : (in_count_reg > N_IN ? N_IN : in_count_reg);
		no = out_count_reg == 0 ? 1 : (out_count_reg > N_OUT ? N_OUT : out_count_reg);
		for (int o = 0; o < no; o++) begin
			acc = 0;
			for (int i = 0; i < ni; i++)
				acc += longint'(inputs[i]) * longint'(weights[i * N_OUT + o]);
			acc = (acc >>> 8) + longint'(biases[o]);
			if (acc > 64'sh7FFFFFFF)
				acc = 64'sh7FFFFFFF;
			if (acc < -64'sh80000000)
				acc = -64'sh80000000;
			v[o] = acc;
		end
		if (act_mode_reg == dlwa_pkg::ACT_SOFTMAX) begin
			mx = v[0];
			sum = 0;
			for (int o = 1; o < no; o++)
				if (v[o] > mx)
					mx = v[o];
			for (int o = 0; o < no; o++) begin
				e[o] = exp_of(v[o] - mx);
				sum += e[o];
			end
			for (int o = 0; o < no; o++) begin
				q = sum != 0 ? ((e[o] << 16) + sum / 2) / sum : 0;
				v[o] = q > 65535 ? 65535 : longint'(q);
			end
		end else begin
			for (int o = 0; o < no; o++) begin
				if (act_mode_reg == dlwa_pkg::ACT_RELU && v[o] < 0)
					v[o] = 0;
				if (v[o] > 65535)
					v[o] = 65535;
				if (v[o] < -65536)
					v[o] = -65536;
			end
		end
		if (keep) begin
			for (int o = 0; o < no; o++) begin
				w.out_value = v[o][16:0];
				w.out_index = o[5:0];
				w.last = (o + 1 == no);
				pending_words.push_back(w);
			end
		end
	endtask

	task automatic apply_word(input dlwa_pkg::in_word_t w, input bit keep);
		case (w.func)
			dlwa_pkg::FUNC_WEIGHT: weights[w.index] = w.value;
			dlwa_pkg::FUNC_BIAS: begin
				if (w.index < N_OUT)
					biases[w.index] = w.value;
			end
			dlwa_pkg::FUNC_INPUT: begin
				if (w.index < N_IN)
					inputs[w.index] = w.value;
				if (w.is_last)
					compute_layer(keep);
			end
			default: ;
		endcase
	endtask

	task automatic send_word(input dlwa_pkg::in_word_t w, input bit typed,
			input logic signed [16:0] result);
		dlwa_pkg::out_word_t t;
		in_data <= w;
		in_valid <= 1'b1;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		apply_word(w, !typed);
		if (typed) begin
			t.out_value = result;
			t.out_index = '0;
			t.last = 1'b1;
			pending_words.push_back(t);
		end
		if (w.func != FUNC_UNKNOWN)
			sent++;
		while (!calm && $urandom_range(99) < 34) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
	endtask

	task automatic wait_idle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending_words.size() != 0)
			@(posedge clk);
		repeat (20)
			@(posedge clk);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [8:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cfg_valid <= 1'b0;
		case (idx)
			dlwa_pkg::CFG_IN_COUNT: in_count_reg = data;
			dlwa_pkg::CFG_OUT_COUNT: out_count_reg = data[6:0];
			dlwa_pkg::CFG_ACTIVATION: act_mode_reg = data[1:0];
			default: ;
		endcase
		@(posedge clk);
	endtask

	function automatic logic signed [15:0] pick_value();
		int r;
		r = $urandom_range(99);
		if (r < 8)
			return 16'sh7FFF;
		if (r < 16)
			return 16'sh8000;
		if (r < 55)
			return 16'($signed($urandom_range(0, 1023)) - 512);
		return 16'($urandom);
	endfunction

	function automatic dlwa_pkg::in_word_t make_word(logic [1:0] f, int idx,
			logic signed [15:0] v, bit lst);
		dlwa_pkg::in_word_t w;
		w.func = f;
		w.index = idx[13:0];
		w.value = v;
		w.is_last = lst;
		return w;
	endfunction

	// Receiver side: random stall and word-by-word check.
	always @(posedge clk) begin
		out_stall <= calm ? 1'b0 : ($urandom_range(99) < 34);
		if (out_valid && !out_stall) begin
			if (pending_words.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected word: %0d idx %0d last %0b",
						out_data.out_value, out_data.out_index, out_data.last);
			end else begin
				if (out_data !== pending_words[0]) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: exp %0d/%0d/%0b got %0d/%0d/%0b",
							pending_words[0].out_value, pending_words[0].out_index,
							pending_words[0].last, out_data.out_value,
							out_data.out_index, out_data.last);
				end
				void'(pending_words.pop_front());
			end
		end
	end

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= STALL_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	initial begin
		table_row_t rows [$];
		int ni, no, n, target;
		logic [1:0] m;

		repeat (2)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		write_reg(dlwa_pkg::CFG_IN_COUNT, 9'd1);
		write_reg(dlwa_pkg::CFG_OUT_COUNT, 9'd1);

		// Fill every entry that a later run can read.
		for (int o = 0; o < N_OUT; o++)
			send_word(make_word(dlwa_pkg::FUNC_WEIGHT, o, pick_value(), 1'b0), 1'b0, '0);
		for (int i = 1; i < FILL_IN; i++)
			for (int o = 0; o < FILL_OUT; o++)
				send_word(make_word(dlwa_pkg::FUNC_WEIGHT, i * N_OUT + o, pick_value(),
					1'b0), 1'b0, '0);
		for (int i = 0; i < N_OUT; i++)
			send_word(make_word(dlwa_pkg::FUNC_BIAS, i, pick_value(), 1'b0), 1'b0, '0);
		for (int i = 0; i < FILL_IN; i++)
			send_word(make_word(dlwa_pkg::FUNC_INPUT, i, pick_value(), i == FILL_IN - 1),
				1'b0, '0);
		wait_idle();

		rows = '{
			'{ACT_NONE, make_word(dlwa_pkg::FUNC_WEIGHT, 0, 16'sh7FFF, 1'b0), 1'b0, '0},
			'{ACT_NONE, make_word(dlwa_pkg::FUNC_BIAS, 0, 16'sh0000, 1'b0), 1'b0, '0},
			'{ACT_NONE, make_word(dlwa_pkg::FUNC_INPUT, 0, 16'sh7FFF, 1'b1), 1'b1,
				17'sd65535},
			'{ACT_NONE, make_word(dlwa_pkg::FUNC_WEIGHT, 0, 16'sh8000, 1'b1), 1'b0, '0},
			'{ACT_NONE, make_word(dlwa_pkg::FUNC_INPUT, 0, 16'sh7FFF, 1'b1), 1'b1,
				-17'sd65536},
			'{dlwa_pkg::ACT_RELU, make_word(dlwa_pkg::FUNC_INPUT, 0, 16'sh7FFF, 1'b1),
				1'b1, 17'sd0},
			'{dlwa_pkg::ACT_SOFTMAX, make_word(dlwa_pkg::FUNC_INPUT, 0, 16'sh7FFF, 1'b1),
				1'b1, 17'sd65535},
			'{ACT_UNKNOWN, make_word(dlwa_pkg::FUNC_WEIGHT, 0, 16'sh0100, 1'b0), 1'b0, '0},
			'{ACT_UNKNOWN, make_word(dlwa_pkg::FUNC_INPUT, 0, 16'sh0100, 1'b1), 1'b1,
				17'sd256},
			'{ACT_UNKNOWN, make_word(dlwa_pkg::FUNC_BIAS, 63, 16'sh8000, 1'b0), 1'b0, '0},
			'{ACT_UNKNOWN, make_word(dlwa_pkg::FUNC_BIAS, 64, 16'sh7FFF, 1'b1), 1'b0, '0},
			'{ACT_UNKNOWN, make_word(dlwa_pkg::FUNC_BIAS, 16383, 16'sh7FFF, 1'b0), 1'b0,
				'0},
			'{ACT_UNKNOWN, make_word(FUNC_UNKNOWN, 16383, 16'shFFFF, 1'b1), 1'b0, '0},
			'{ACT_UNKNOWN, make_word(dlwa_pkg::FUNC_WEIGHT, 16383, 16'sh5A5A, 1'b1), 1'b0,
				'0},
			'{ACT_UNKNOWN, make_word(dlwa_pkg::FUNC_INPUT, 255, 16'sh0000, 1'b0), 1'b0, '0},
			'{ACT_UNKNOWN, make_word(dlwa_pkg::FUNC_INPUT, 16383, 16'sh7FFF, 1'b1), 1'b1,
				17'sd256},
			'{ACT_UNKNOWN, make_word(dlwa_pkg::FUNC_INPUT, 0, 16'shFFFF, 1'b1), 1'b1,
				-17'sd1},
			'{ACT_NONE, make_word(dlwa_pkg::FUNC_INPUT, 0, 16'sh2A5A, 1'b1), 1'b0, '0}
		};
		foreach (rows[r]) begin
			if (rows[r].mode != act_mode_reg) begin
				wait_idle();
				write_reg(dlwa_pkg::CFG_ACTIVATION, {7'd0, rows[r].mode});
			end
			send_word(rows[r].word, rows[r].typed, rows[r].result);
		end

		for (int phase = 0; phase < 8; phase++) begin
			wait_idle();
			case (phase)
				0: begin
					write_reg(dlwa_pkg::CFG_IN_COUNT, 9'd1);
					write_reg(dlwa_pkg::CFG_OUT_COUNT, 9'd127);
					write_reg(dlwa_pkg::CFG_ACTIVATION, {7'd0, dlwa_pkg::ACT_SOFTMAX});
				end
				1: begin
					write_reg(dlwa_pkg::CFG_IN_COUNT, 9'd0);
					write_reg(dlwa_pkg::CFG_OUT_COUNT, 9'd0);
					write_reg(dlwa_pkg::CFG_ACTIVATION, {7'd0, dlwa_pkg::ACT_RELU});
				end
				2: begin
					write_reg(dlwa_pkg::CFG_IN_COUNT, 9'(FILL_IN));
					write_reg(dlwa_pkg::CFG_OUT_COUNT, 9'(FILL_OUT));
					write_reg(dlwa_pkg::CFG_ACTIVATION, {7'd0, dlwa_pkg::ACT_SOFTMAX});
				end
				default: begin
					write_reg(dlwa_pkg::CFG_IN_COUNT, 9'($urandom_range(1, FILL_IN)));
					write_reg(dlwa_pkg::CFG_OUT_COUNT, 9'($urandom_range(1, FILL_OUT)));
					write_reg(dlwa_pkg::CFG_ACTIVATION, 9'($urandom_range(0, 3)));
				end
			endcase
			calm = (phase == 4);
			ni = in_count_reg == 0 ? 1 : (in_count_reg > N_IN ? N_IN : in_count_reg);
			no = out_count_reg == 0 ? 1 : (out_count_reg > N_OUT ? N_OUT : out_count_reg);
			target = sent + 18;
			while (sent < target) begin
				if ($urandom_range(99) < 75) begin
					n = $urandom_range(0, 3);
					for (int k = 0; k < n; k++)
						send_word(make_word(dlwa_pkg::FUNC_WEIGHT,
							$urandom_range(0, ni - 1) * N_OUT +
							$urandom_range(0, no - 1),
							pick_value(), 1'($urandom_range(1))), 1'b0, '0);
					n = $urandom_range(0, 2);
					for (int k = 0; k < n; k++)
						send_word(make_word(dlwa_pkg::FUNC_BIAS, $urandom_range(0, no - 1),
							pick_value(), 1'b0), 1'b0, '0);
					n = ni < 6 ? ni : 6;
					for (int k = 0; k < n; k++)
						send_word(make_word(dlwa_pkg::FUNC_INPUT,
							n == ni ? k : $urandom_range(0, ni - 1),
							pick_value(), k == n - 1), 1'b0, '0);
				end else begin
					m = 2'($urandom_range(0, 3));
					send_word(make_word(m, $urandom_range(0, 16383), 16'($urandom),
						1'($urandom_range(1))), 1'b0, '0);
				end
			end
			calm = 1'b0;
		end

		wait_idle();
		repeat (50)
			@(posedge clk);
		if (mismatches == 0 && pending_words.size() == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
